### rtl/core/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// Used by every module of the block and by its checker; no dependencies.
package tli_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;
	localparam int POS_W       = 26;
	localparam int FRAC_BITS   = 16;
	localparam int DEPTH_DEF   = 1024;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 64;

	// Request kinds carried on the input tuser bit.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [1:0] {
		RANGE_IN    = 2'd0,
		RANGE_BELOW = 2'd1,
		RANGE_ABOVE = 2'd2
	} range_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_X0, ST_XN, ST_CHK, ST_BREQ, ST_BCMP, ST_DEC,
		ST_RXLO, ST_RXHI, ST_DSET, ST_DIV, ST_RYLO, ST_RYHI,
		ST_MUL1, ST_MUL2, ST_SUM, ST_EMIT
	} state_t;

	// Table write request.
	typedef struct packed {
		logic                     en;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
	} tbl_wr_t;

endpackage

### rtl/core/tli_table.sv
// Breakpoint storage: x and y memories, one write and one registered read each.
// Depends on tli_pkg.
module tli_table #(
	parameter int TABLE_DEPTH = tli_pkg::DEPTH_DEF,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                             clk,
	input  tli_pkg::tbl_wr_t                 wr,
	input  logic [AW-1:0]                    x_raddr,
	input  logic [AW-1:0]                    y_raddr,
	output logic signed [tli_pkg::DATA_W-1:0] x_rdata,
	output logic signed [tli_pkg::DATA_W-1:0] y_rdata
);
	import tli_pkg::*;

	logic signed [DATA_W-1:0] x_mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0] y_mem [TABLE_DEPTH];
	logic                     wr_ok;

	// Writes beyond the table are dropped.
	assign wr_ok = wr.en && (32'(wr.idx) < 32'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			x_mem[AW'(wr.idx)] <= wr.x;
			y_mem[AW'(wr.idx)] <= wr.y;
		end
		x_rdata <= x_mem[x_raddr];
		y_rdata <= y_mem[y_raddr];
	end

endmodule

### rtl/core/tli_div.sv
// Restoring divider giving floor(num * 2^FRAC_BITS / den), one bit per cycle.
// Requires num < den. Depends on tli_pkg.
module tli_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tli_pkg::DATA_W:0]       num,
	input  logic [tli_pkg::DATA_W:0]       den,
	output logic                           done,
	output logic [tli_pkg::FRAC_BITS-1:0]  quot
);
	import tli_pkg::*;

	localparam int SW = $clog2(FRAC_BITS + 1);

	logic [DATA_W+1:0]   rem_q;
	logic [DATA_W:0]     den_q;
	logic [SW-1:0]       steps_q;
	logic [DATA_W+1:0]   shifted;
	logic                fits;

	assign shifted = {rem_q[DATA_W:0], 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	// Step counter: control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= (steps_q == SW'(1));
			if (start) steps_q <= SW'(FRAC_BITS);
			else if (steps_q != '0) steps_q <= steps_q - SW'(1);
		end
	end

	// One quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot  <= '0;
		end else if (steps_q != '0) begin
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			quot  <= {quot[FRAC_BITS-2:0], fits};
		end
	end

endmodule

### rtl/core/table_linear_interpolator.sv
// Piecewise linear interpolator over a loaded breakpoint table.
// Table writes are taken back to back in the idle state. A query runs two
// binary searches, each step an x read then a compare, then a fraction divide,
// then two y reads and two registered multiplies.
// Exact matches and clamped targets skip the divide path.
// Results sit in an output register so the next request is taken meanwhile.
// Reset (arst_n low) clears control and sets entries_q to 2; table unset.
module table_linear_interpolator #(
	parameter int TABLE_DEPTH = tli_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// tdata: entry_index[9:0], x_value[41:10], y_value[73:42], target[105:74]
	input  logic [tli_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// tuser: func
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: y_result[31:0], frac_index[57:32]
	output logic [tli_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// tuser: range_status
	output logic [1:0]                         m_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [tli_pkg::CNT_W-1:0]          cfg_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready
);
	import tli_pkg::*;

	localparam int AW        = $clog2(TABLE_DEPTH);
	localparam int DEPTH_CAP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
	localparam int PW        = 2 * DATA_W - 14;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	state_t state_q, state_d;

	logic [CNT_W-1:0]          entries_q, n_q, first_q, count_q, mid_q, a_q, lo_q, hi_q;
	logic                      upper_q, interp_q;
	logic signed [DATA_W-1:0]  t_q, x0_q, xlo_q, ylo_q, yhi_q, y_res_q;
	logic [FRAC_BITS-1:0]      f_q;
	logic [POS_W-1:0]          pos_q;
	range_t                    stat_q;
	logic signed [PW-1:0]      p1_q, p2_q;

	logic                      s_acc, m_room, div_start, div_done;
	logic [CNT_W-1:0]          n_in, step, a_adj;
	logic [CNT_W:0]            s_sum;
	logic [AW-1:0]             x_raddr, y_raddr;
	logic signed [DATA_W-1:0]  x_rdata, y_rdata;
	logic signed [DATA_W:0]    d_w, off_w;
	logic [FRAC_BITS-1:0]      quot;
	logic                      go_right;
	logic signed [PW:0]        num_w, num_adj;
	tbl_wr_t                   wr;

	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign m_room    = !m_axis_tvalid || m_axis_tready;
	assign cfg_ready = 1'b1;
	assign step      = count_q >> 1;
	assign s_sum     = {1'b0, a_q} + {1'b0, first_q} - (CNT_W+1)'(1);
	assign a_adj     = (a_q == '0) ? CNT_W'(1) : ((a_q >= n_q) ? n_q - CNT_W'(1) : a_q);
	assign d_w       = {x_rdata[DATA_W-1], x_rdata} - {xlo_q[DATA_W-1], xlo_q};
	assign off_w     = {t_q[DATA_W-1], t_q} - {xlo_q[DATA_W-1], xlo_q};
	assign go_right  = upper_q ? (x_rdata <= t_q) : (x_rdata < t_q);
	assign num_w     = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
	assign num_adj   = num_w[PW] ? num_w + (PW+1)'(ONE - 1'b1) : num_w;

	// Searched entry count clamped into the table.
	assign n_in = (entries_q < CNT_W'(2)) ? CNT_W'(2) :
		((32'(entries_q) > DEPTH_CAP) ? CNT_W'(DEPTH_CAP) : entries_q);

	// Table write request.
	always_comb begin
		wr.en  = s_acc && (s_axis_tuser == FUNC_WRITE);
		wr.idx = s_axis_tdata[9:0];
		wr.x   = s_axis_tdata[41:10];
		wr.y   = s_axis_tdata[73:42];
	end

	tli_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk(clk), .wr(wr), .x_raddr(x_raddr), .y_raddr(y_raddr),
		.x_rdata(x_rdata), .y_rdata(y_rdata)
	);

	tli_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(off_w), .den(d_w), .done(div_done), .quot(quot)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) entries_q <= CNT_W'(2);
		else if (cfg_valid && cfg_ready) entries_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Sequencer: next state, memory addresses and handshakes.
	always_comb begin
		state_d       = state_q;
		x_raddr       = AW'(mid_q);
		y_raddr       = AW'(lo_q);
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_acc && s_axis_tuser == FUNC_QUERY) state_d = ST_X0;
			end
			ST_X0: begin
				x_raddr = '0;
				state_d = ST_XN;
			end
			ST_XN: begin
				x_raddr = AW'(n_q - CNT_W'(1));
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (t_q < x0_q || t_q > x_rdata) state_d = ST_RYLO;
				else state_d = ST_BREQ;
			end
			ST_BREQ: begin
				x_raddr = AW'(first_q + step);
				if (count_q != '0) state_d = ST_BCMP;
				else if (upper_q) state_d = ST_DEC;
			end
			ST_BCMP: state_d = ST_BREQ;
			ST_DEC: begin
				state_d = (a_q < first_q) ? ST_RYLO : ST_RXLO;
			end
			ST_RXLO: begin
				x_raddr = AW'(lo_q);
				state_d = ST_RXHI;
			end
			ST_RXHI: begin
				x_raddr = AW'(hi_q);
				state_d = ST_DSET;
			end
			ST_DSET: begin
				if (d_w <= 0 || off_w <= 0 || off_w >= d_w) begin
					state_d = ST_RYLO;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: if (div_done) state_d = ST_RYLO;
			ST_RYLO: begin
				y_raddr = AW'(lo_q);
				state_d = ST_RYHI;
			end
			ST_RYHI: begin
				y_raddr = AW'(hi_q);
				state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_EMIT: if (m_room) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q      <= s_axis_tdata[105:74];
				n_q      <= n_in;
				first_q  <= '0;
				count_q  <= n_in;
				upper_q  <= 1'b0;
				interp_q <= 1'b0;
				f_q      <= '0;
				stat_q   <= RANGE_IN;
			end
			ST_XN: x0_q <= x_rdata;
			ST_CHK: begin
				if (t_q < x0_q) begin
					stat_q <= RANGE_BELOW;
					lo_q   <= '0;
					hi_q   <= '0;
					pos_q  <= '0;
				end else if (t_q > x_rdata) begin
					stat_q <= RANGE_ABOVE;
					lo_q   <= n_q - CNT_W'(1);
					hi_q   <= n_q - CNT_W'(1);
					pos_q  <= POS_W'({n_q - CNT_W'(1), {FRAC_BITS{1'b0}}});
				end
			end
			ST_BREQ: begin
				mid_q <= first_q + step;
				if (count_q == '0 && !upper_q) begin
					a_q     <= first_q;
					upper_q <= 1'b1;
					first_q <= '0;
					count_q <= n_q;
				end
			end
			ST_BCMP: begin
				if (go_right) begin
					first_q <= mid_q + CNT_W'(1);
					count_q <= count_q - step - CNT_W'(1);
				end else begin
					count_q <= step;
				end
			end
			ST_DEC: begin
				if (a_q < first_q) begin
					// Run of exact matches: take its center.
					pos_q <= POS_W'({s_sum, {(FRAC_BITS-1){1'b0}}});
					lo_q  <= s_sum[CNT_W:1];
					if (!s_sum[0] || ({1'b0, s_sum[CNT_W:1]} + 1'b1) >= {1'b0, n_q}) begin
						hi_q <= s_sum[CNT_W:1];
					end else begin
						hi_q <= s_sum[CNT_W:1] + CNT_W'(1);
						f_q  <= FRAC_BITS'(1) << (FRAC_BITS - 1);
					end
				end else begin
					interp_q <= 1'b1;
					lo_q     <= a_adj - CNT_W'(1);
					hi_q     <= a_adj;
				end
			end
			ST_RXHI: xlo_q <= x_rdata;
			ST_DSET: begin
				if (d_w > 0 && off_w > 0 && off_w >= d_w) f_q <= '1;
			end
			ST_DIV: if (div_done) f_q <= quot;
			ST_RYLO: if (interp_q) pos_q <= POS_W'({lo_q, f_q});
			ST_RYHI: ylo_q <= y_rdata;
			ST_MUL1: begin
				yhi_q <= y_rdata;
				p1_q  <= ylo_q * $signed({1'b0, ONE - {1'b0, f_q}});
			end
			ST_MUL2: p2_q <= yhi_q * $signed({2'b0, f_q});
			ST_SUM:  y_res_q <= num_adj[FRAC_BITS+DATA_W-1:FRAC_BITS];
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == ST_EMIT && m_room) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && m_room) begin
			m_axis_tdata <= {{(OUT_TDATA_W-POS_W-DATA_W){1'b0}}, pos_q, y_res_q};
			m_axis_tuser <= stat_q;
		end
	end

endmodule

### rtl/core/tli_checker.sv
// Port-level checks for the table linear interpolator, bound to its top level.
// Depends on tli_pkg.
module tli_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tuser,
	input logic [tli_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                      m_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready
);
	import tli_pkg::*;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// A table write never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_WRITE && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result after a table write");

	// A query occupies the block: no request is taken the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_QUERY |=> !s_axis_tready)
		else $error("request taken during a query");

	// Below-range clamp sits at position zero; status code is legal.
	a_below_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == RANGE_IN) || (m_axis_tuser == RANGE_ABOVE)
		|| (m_axis_tuser == RANGE_BELOW && m_axis_tdata[57:32] == '0))
		else $error("bad range status or clamp position");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);

### sim/table_linear_interpolator_test.sv
// Self-checking testbench for table_linear_interpolator: table loads and
// interpolation queries checked against an in-bench fixed-point predictor.
// Depends on tli_pkg and the table_linear_interpolator RTL only.
module table_linear_interpolator_test;
	import tli_pkg::*;

	localparam int DEPTH = 1024;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic [DATA_W-1:0] y;
		logic [POS_W-1:0]  pos;
		range_t            status;
	} interp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;

	table_linear_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the table copy and the entry count.
	logic signed [DATA_W-1:0] x_tbl [DEPTH];
	logic signed [DATA_W-1:0] y_tbl [DEPTH];
	logic [CNT_W-1:0] entry_count = 11'd2;
	int written_top = 0;
	interp_t pending_results[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int cycles = 0;

	function automatic int search_bound(int n, longint t, bit or_equal);
		int first, count, step, it;
		bit go_right;
		first = 0;
		count = n;
		while (count > 0) begin
			step = count / 2;
			it = first + step;
			go_right = or_equal ? (longint'(x_tbl[it]) <= t) : (longint'(x_tbl[it]) < t);
			if (go_right) begin
				first = it + 1;
				count -= step + 1;
			end else begin
				count = step;
			end
		end
		return first;
	endfunction

	function automatic longint mix_y(int lo, int hi, longint f);
		longint one, num;
		one = longint'(1) << FRAC_BITS;
		num = longint'(y_tbl[lo]) * (one - f) + longint'(y_tbl[hi]) * f;
		return num / one;
	endfunction

	function automatic interp_t interpolate(logic signed [DATA_W-1:0] target);
		interp_t r;
		int n, a, ub, s, k, lo, hi;
		longint t, y, pos, d, off, f;
		n = entry_count < 2 ? 2 : (entry_count > DEPTH ? DEPTH : int'(entry_count));
		t = target;
		r.status = RANGE_IN;
		if (t < x_tbl[0]) begin
			r.status = RANGE_BELOW;
			y = y_tbl[0];
			pos = 0;
		end else if (t > x_tbl[n-1]) begin
			r.status = RANGE_ABOVE;
			y = y_tbl[n-1];
			pos = longint'(n - 1) << FRAC_BITS;
		end else begin
			a = search_bound(n, t, 1'b0);
			ub = search_bound(n, t, 1'b1);
			if (a < ub) begin
				// Run of equal x values: take y at its center.
				s = a + ub - 1;
				k = s >> 1;
				pos = longint'(s) << (FRAC_BITS - 1);
				if (s % 2 == 0 || k + 1 >= n) y = y_tbl[k];
				else y = mix_y(k, k + 1, longint'(1) << (FRAC_BITS - 1));
			end else begin
				if (a == 0) a = 1;
				if (a >= n) a = n - 1;
				lo = a - 1;
				hi = a;
				d = longint'(x_tbl[hi]) - longint'(x_tbl[lo]);
				off = t - longint'(x_tbl[lo]);
				if (d <= 0 || off <= 0) f = 0;
				else begin
					f = (off << FRAC_BITS) / d;
					if (f > (longint'(1) << FRAC_BITS) - 1) f = (longint'(1) << FRAC_BITS) - 1;
				end
				pos = (longint'(lo) << FRAC_BITS) + f;
				y = mix_y(lo, hi, f);
			end
		end
		r.y = y[DATA_W-1:0];
		r.pos = pos[POS_W-1:0];
		return r;
	endfunction

	// Checks each result against the oldest expectation.
	always @(posedge clk) begin
		interp_t got, want;
		cycles <= cycles + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			got.y = m_axis_tdata[31:0];
			got.pos = m_axis_tdata[57:32];
			got.status = range_t'(m_axis_tuser);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result y=%h pos=%h st=%0d",
					got.y, got.pos, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got.y !== want.y || got.pos !== want.pos || got.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result differs: expected y=%h pos=%h st=%0d, got y=%h pos=%h st=%0d",
							want.y, want.pos, want.status, got.y, got.pos, got.status);
				end
			end
		end
	end

	// Receiver stalls change at the falling edge.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk)
		if (cycles > LIMIT) begin
			$display("table_linear_interpolator: mismatch");
			$finish;
		end

	// The valid line stays up after a request until the next one or an idle cycle.
	task automatic send_request(bit func, int idx, logic [31:0] x, logic [31:0] y,
		logic [31:0] target);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser <= func;
		s_axis_tdata <= {6'b0, target, y, x, idx[IDX_W-1:0]};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (func == FUNC_WRITE) begin
			x_tbl[idx] = x;
			y_tbl[idx] = y;
		end else begin
			pending_results.push_back(interpolate(target));
		end
		@(negedge clk);
	endtask

	task automatic write_entry(int idx, logic [31:0] x, logic [31:0] y);
		send_request(FUNC_WRITE, idx, x, y, $urandom());
		if (idx >= written_top) written_top = idx + 1;
	endtask

	task automatic query(logic [31:0] target);
		send_request(FUNC_QUERY, $urandom_range(1023), $urandom(), $urandom(), target);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_entry_count(int n);
		drain();
		cfg_data <= n[CNT_W-1:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		entry_count = n[CNT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Loads a sorted table of n entries; dup_pct sets how often x repeats.
	task automatic load_sorted(int n, int dup_pct, int max_step);
		logic signed [31:0] x;
		x = -32'sd1 * $urandom_range(max_step * n / 2 + 1);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(99) >= dup_pct) x = x + $urandom_range(max_step, 1);
			write_entry(i, x, $urandom());
		end
	endtask

	function automatic logic [31:0] pick_target(int n);
		int i;
		i = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return x_tbl[i];
			1: return x_tbl[i] + $urandom_range(3) - 1;
			2: return $urandom();
			default: return x_tbl[i] + $urandom_range(1 << 20);
		endcase
	endfunction

	task automatic test_extremes();
		// Field extremes, a run of equal x, and clamping above the last entry.
		write_entry(0, 32'h8000_0000, 32'h7FFF_FFFF);
		write_entry(1, 32'h0000_0000, 32'h8000_0000);
		write_entry(2, 32'h0000_0000, 32'h1234_5678);
		write_entry(3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		set_entry_count(2);
		query(32'h8000_0000);
		query(32'h7FFF_FFFF);
		query(32'hC000_0000);
		set_entry_count(4);
		query(32'h0000_0000);
		query(32'h0000_0001);
		query(32'h7FFF_FFFF);
		query(32'hFFFF_FFFF);
		// Write beyond the searched count, then an out-of-order table.
		write_entry(1023, 32'hFFFF_FFFF, 32'h0000_0001);
		write_entry(2, 32'hF000_0000, 32'h5555_AAAA);
		query(32'hF800_0000);
		query(32'h0000_0000);
		query(32'h1000_0000);
	endtask

	task automatic test_counts();
		// Entry counts below 2 and above the table act as the nearest bound.
		load_sorted(DEPTH, 5, 4096);
		set_entry_count(0);
		query(pick_target(2));
		set_entry_count(1);
		query(pick_target(2));
		set_entry_count(2047);
		query(pick_target(DEPTH));
		query(32'h7FFF_FFFF);
		set_entry_count(DEPTH);
		query(x_tbl[DEPTH-1]);
		query(32'h8000_0000);
	endtask

	// The whole table is written by then, so a full count needs no reload.
	task automatic test_random(int items);
		int n;
		n = 2;
		for (int i = 0; i < items; i++) begin
			if (i % 40 == 0) begin
				if ($urandom_range(9) == 0) begin
					n = DEPTH;
					set_entry_count(n);
				end else begin
					n = $urandom_range(16, 2);
					set_entry_count(n);
					load_sorted(n, $urandom_range(40), $urandom_range(1 << 18, 1));
				end
			end
			if ($urandom_range(19) == 0) write_entry($urandom_range(n - 1), $urandom(), $urandom());
			else query(pick_target(n));
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 23; recv_idle_pct = 83;
		test_extremes();
		test_counts();
		test_random(65);
		drain();
		send_idle_pct = 83; recv_idle_pct = 23;
		test_random(65);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(65);
		drain();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("table_linear_interpolator: match");
		else
			$display("table_linear_interpolator: mismatch");
		$finish;
	end
endmodule
